// File: src/opwc_pkg.sv
// Shared types and constants of the OTP PIN window checker.
// No dependencies; every other file of the block imports this package.
package opwc_pkg;

  typedef struct packed {
    logic [1:0]  pin_kind;
    logic [15:0] key_id;
    logic        has_card;
    logic [31:0] card_number;
    logic [1:0]  digit_code;
    logic [7:0]  follow_window;
    logic [7:0]  previous_window;
    logic [31:0] hotp_counter;
    logic [7:0]  interval_minutes;
    logic [31:0] now_seconds;
    logic [31:0] candidate_pin;
  } in_item_t;

  typedef struct packed {
    logic        accepted;
    logic        counter_update;
    logic [31:0] next_counter;
  } out_item_t;

  // Control from the sequencer to the hash core
  typedef struct packed {
    logic start;
    logic use_iv;
  } sha_ctl_t;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_ROOT_W0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROOT_W1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROOT_W2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ROOT_W3 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_EPOCH   = 3'd4;

  localparam logic [1:0] KIND_HOTP = 2'd0;
  localparam logic [1:0] KIND_TOTP = 2'd1;

  localparam logic [1:0] DIG_6 = 2'd0;
  localparam logic [1:0] DIG_7 = 2'd1;
  localparam logic [1:0] DIG_8 = 2'd2;

  localparam logic [7:0] IPAD = 8'h36;
  localparam logic [7:0] OPAD = 8'h5C;
  localparam logic [7:0] MSG_END = 8'h80;

  localparam logic [159:0] SHA1_IV =
    160'h67452301_EFCDAB89_98BADCFE_10325476_C3D2E1F0;
  localparam logic [31:0] SHA1_K0 = 32'h5A827999;
  localparam logic [31:0] SHA1_K1 = 32'h6ED9EBA1;
  localparam logic [31:0] SHA1_K2 = 32'h8F1BBCDC;
  localparam logic [31:0] SHA1_K3 = 32'hCA62C1D6;

  localparam int SHA1_ROUNDS = 80;
  localparam int BIN_W = 31;

endpackage

// File: src/opwc_sha1_core.sv
// Iterative SHA-1 compression unit: one round per clock, 16-word schedule window.
// Depends on opwc_pkg.
module opwc_sha1_core (
  input  logic               clk,
  input  logic               rst_n,
  input  opwc_pkg::sha_ctl_t ctl,
  input  logic [511:0]       block,
  output logic               done,
  output logic [159:0]       digest
);
  import opwc_pkg::*;

  logic [31:0] w_r [16];
  logic [31:0] a_r, b_r, c_r, d_r, e_r;
  logic [31:0] h_r [5];
  logic [6:0]  cnt_r;
  logic        busy_r, fin_r, done_r;
  logic [31:0] f, k, tmp, wx, wnew;

  always_comb begin
    priority if (cnt_r < 7'd20) begin
      f = (b_r & c_r) | (~b_r & d_r);
      k = SHA1_K0;
    end else if (cnt_r < 7'd40) begin
      f = b_r ^ c_r ^ d_r;
      k = SHA1_K1;
    end else if (cnt_r < 7'd60) begin
      f = (b_r & c_r) | (b_r & d_r) | (c_r & d_r);
      k = SHA1_K2;
    end else begin
      f = b_r ^ c_r ^ d_r;
      k = SHA1_K3;
    end
    tmp  = {a_r[26:0], a_r[31:27]} + f + e_r + k + w_r[0];
    wx   = w_r[13] ^ w_r[8] ^ w_r[2] ^ w_r[0];
    wnew = {wx[30:0], wx[31]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (ctl.start) begin
        for (int i = 0; i < 16; i++) w_r[i] <= block[511-32*i -: 32];
        if (ctl.use_iv) begin
          for (int i = 0; i < 5; i++) h_r[i] <= SHA1_IV[159-32*i -: 32];
          a_r <= SHA1_IV[159:128];
          b_r <= SHA1_IV[127:96];
          c_r <= SHA1_IV[95:64];
          d_r <= SHA1_IV[63:32];
          e_r <= SHA1_IV[31:0];
        end else begin
          a_r <= h_r[0];
          b_r <= h_r[1];
          c_r <= h_r[2];
          d_r <= h_r[3];
          e_r <= h_r[4];
        end
        cnt_r  <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        a_r <= tmp;
        b_r <= a_r;
        c_r <= {b_r[1:0], b_r[31:2]};
        d_r <= c_r;
        e_r <= d_r;
        for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
        w_r[15] <= wnew;
        if (cnt_r == 7'(SHA1_ROUNDS - 1)) begin
          busy_r <= 1'b0;
          fin_r  <= 1'b1;
        end
        cnt_r <= cnt_r + 7'd1;
      end else if (fin_r) begin
        // fold the block result into the chaining value
        h_r[0] <= h_r[0] + a_r;
        h_r[1] <= h_r[1] + b_r;
        h_r[2] <= h_r[2] + c_r;
        h_r[3] <= h_r[3] + d_r;
        h_r[4] <= h_r[4] + e_r;
        fin_r  <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  assign done   = done_r;
  assign digest = {h_r[0], h_r[1], h_r[2], h_r[3], h_r[4]};

endmodule

// File: src/opwc_div.sv
// Restoring divider, one quotient bit per clock, for the time step counter.
// Depends on opwc_pkg.
module opwc_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [13:0] divisor,
  output logic        done,
  output logic [31:0] quotient
);
  import opwc_pkg::*;

  logic [31:0] q_r;
  logic [13:0] rem_r, div_r;
  logic [4:0]  cnt_r;
  logic        busy_r, done_r;
  logic [15:0] diff;

  assign diff = {1'b0, rem_r, q_r[31]} - {2'b00, div_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        q_r    <= dividend;
        div_r  <= divisor;
        rem_r  <= '0;
        cnt_r  <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        if (!diff[15]) begin
          rem_r <= diff[13:0];
          q_r   <= {q_r[30:0], 1'b1};
        end else begin
          rem_r <= {rem_r[12:0], q_r[31]};
          q_r   <= {q_r[30:0], 1'b0};
        end
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

// File: src/opwc_bcd.sv
// Binary to BCD converter (shift and add-3), one input bit per clock.
// Depends on opwc_pkg.
module opwc_bcd (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [30:0]      bin,
  output logic             done,
  output logic [39:0]      bcd
);
  import opwc_pkg::*;

  logic [30:0] bin_r;
  logic [39:0] bcd_r, adj;
  logic [4:0]  cnt_r;
  logic        busy_r, done_r;

  always_comb begin
    for (int i = 0; i < 10; i++) begin
      adj[4*i +: 4] = (bcd_r[4*i +: 4] >= 4'd5) ? bcd_r[4*i +: 4] + 4'd3 : bcd_r[4*i +: 4];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        bin_r  <= bin;
        bcd_r  <= '0;
        cnt_r  <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        bcd_r <= {adj[38:0], bin_r[BIN_W-1]};
        bin_r <= {bin_r[29:0], 1'b0};
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'(BIN_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign bcd  = bcd_r;

endmodule

// File: src/otp_pin_window_checker.sv
// Top level of the OTP PIN window checker: sequencer, block builder, registers.
// Depends on opwc_pkg, opwc_sha1_core, opwc_div and opwc_bcd.
//
// One transaction is worked on at a time; in_ready is high only while idle.
// The work is set by the single SHA-1 round unit, which hashes one 64-byte
// block at a time. Key derivation costs four blocks, each tried counter
// four more blocks plus a BCD conversion, and a TOTP transaction first
// adds a division. A rejected pin kind or digit count goes straight to the
// output state. The result waits in an output register, so a new
// transaction can be taken while it is still unread.
module otp_pin_window_checker #(
  parameter int ROOT_KEY_BYTES    = 32,
  parameter int DERIVED_KEY_BYTES = 20
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  opwc_pkg::in_item_t                   in_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output opwc_pkg::out_item_t                  out_data,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [opwc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [63:0]                          cfg_data
);
  import opwc_pkg::*;

  localparam logic [255:0] RK_MASK = {256{1'b1}} << (256 - 8*ROOT_KEY_BYTES);
  localparam logic [159:0] DK_MASK = {160{1'b1}} << (160 - 8*DERIVED_KEY_BYTES);

  typedef enum logic [2:0] {S_IDLE, S_DIV, S_HSTART, S_HWAIT, S_BCD, S_OUT} state_t;

  state_t      state_r;
  in_item_t    item_r;
  out_item_t   res_r, out_r;
  logic        out_valid_r;
  logic [63:0] rk0_r, rk1_r, rk2_r, rk3_r;
  logic [31:0] epoch_r;
  logic [31:0] c_r, cand_r;
  logic [7:0]  step_r;
  logic        back_r, derive_r;
  logic [1:0]  blk_r;
  logic [159:0] inner_r, key_r;

  logic         accept;
  logic         div_start, div_done;
  logic [31:0]  div_q;
  logic [13:0]  divisor;
  sha_ctl_t     sha_ctl;
  logic         sha_done;
  logic [159:0] sha_digest;
  logic [511:0] block;
  logic [7:0]   bb [64];
  logic [255:0] rk_m;
  logic [159:0] trunc_sel;
  logic         bcd_start, bcd_done;
  logic [39:0]  bcd;
  logic [31:0]  code;
  logic [7:0]   prev_eff;

  assign accept    = in_valid && in_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Configuration registers; indexes past the list are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rk0_r   <= '0;
      rk1_r   <= '0;
      rk2_r   <= '0;
      rk3_r   <= '0;
      epoch_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ROOT_W0: rk0_r <= cfg_data;
        REG_ROOT_W1: rk1_r <= cfg_data;
        REG_ROOT_W2: rk2_r <= cfg_data;
        REG_ROOT_W3: rk3_r <= cfg_data;
        REG_EPOCH:   epoch_r <= cfg_data[31:0];
        default:     ;
      endcase
    end
  end

  assign divisor   = (in_data.interval_minutes == 8'd0) ? 14'd30 :
                     (14'(in_data.interval_minutes) << 6) - (14'(in_data.interval_minutes) << 2);
  assign div_start = accept && (in_data.pin_kind == KIND_TOTP) && (in_data.digit_code != 2'd3);

  opwc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (in_data.now_seconds + epoch_r),
    .divisor  (divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  // Build the 64-byte block for the current step of the HMAC
  assign rk_m = {rk0_r, rk1_r, rk2_r, rk3_r} & RK_MASK;

  always_comb begin
    for (int i = 0; i < 64; i++) bb[i] = 8'h00;
    unique case (blk_r)
      2'd0, 2'd2: begin
        for (int i = 0; i < 64; i++) bb[i] = (blk_r == 2'd0) ? IPAD : OPAD;
        if (derive_r) begin
          for (int i = 0; i < 32; i++) bb[i] = bb[i] ^ rk_m[255-8*i -: 8];
        end else begin
          for (int i = 0; i < 20; i++) bb[i] = bb[i] ^ key_r[159-8*i -: 8];
        end
      end
      2'd1: begin
        if (derive_r) begin
          bb[0] = item_r.key_id[15:8];
          bb[1] = item_r.key_id[7:0];
          if (item_r.has_card) begin
            bb[2]  = item_r.card_number[31:24];
            bb[3]  = item_r.card_number[23:16];
            bb[4]  = item_r.card_number[15:8];
            bb[5]  = item_r.card_number[7:0];
            bb[6]  = 8'h01;
            bb[7]  = MSG_END;
            bb[62] = 8'h02;
            bb[63] = 8'h38;
          end else begin
            bb[2]  = 8'h01;
            bb[3]  = MSG_END;
            bb[62] = 8'h02;
            bb[63] = 8'h18;
          end
        end else begin
          bb[4]  = cand_r[31:24];
          bb[5]  = cand_r[23:16];
          bb[6]  = cand_r[15:8];
          bb[7]  = cand_r[7:0];
          bb[8]  = MSG_END;
          bb[62] = 8'h02;
          bb[63] = 8'h40;
        end
      end
      2'd3: begin
        for (int i = 0; i < 20; i++) bb[i] = inner_r[159-8*i -: 8];
        bb[20] = MSG_END;
        bb[62] = 8'h02;
        bb[63] = 8'hA0;
      end
      default: ;
    endcase
    for (int i = 0; i < 64; i++) block[511-8*i -: 8] = bb[i];
  end

  assign sha_ctl.start  = (state_r == S_HSTART);
  assign sha_ctl.use_iv = !blk_r[0];

  opwc_sha1_core u_sha (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (sha_ctl),
    .block  (block),
    .done   (sha_done),
    .digest (sha_digest)
  );

  // Dynamic truncation: four bytes at the offset named by the last nibble
  assign trunc_sel = sha_digest << {sha_digest[3:0], 3'b000};
  assign bcd_start = (state_r == S_HWAIT) && sha_done && (blk_r == 2'd3) && !derive_r;

  opwc_bcd u_bcd (
    .clk   (clk),
    .rst_n (rst_n),
    .start (bcd_start),
    .bin   (trunc_sel[158:128]),
    .done  (bcd_done),
    .bcd   (bcd)
  );

  always_comb begin
    unique case (item_r.digit_code)
      DIG_6:   code = {8'hFF, bcd[23:0]};
      DIG_7:   code = {4'hF, bcd[27:0]};
      DIG_8:   code = bcd[31:0];
      default: code = '0;
    endcase
  end

  assign prev_eff = (item_r.pin_kind == KIND_HOTP) ? 8'd0 : item_r.previous_window;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      derive_r    <= 1'b0;
      back_r      <= 1'b0;
      blk_r       <= '0;
      step_r      <= '0;
    end else begin
      // S_OUT reloads the output register itself
      if (out_valid_r && out_ready && state_r != S_OUT) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            item_r   <= in_data;
            res_r    <= '0;
            derive_r <= 1'b1;
            blk_r    <= '0;
            c_r      <= in_data.hotp_counter;
            if (in_data.pin_kind[1] || in_data.digit_code == 2'd3) begin
              state_r <= S_OUT;
            end else if (in_data.pin_kind == KIND_TOTP) begin
              state_r <= S_DIV;
            end else begin
              state_r <= S_HSTART;
            end
          end
        end
        S_DIV: begin
          if (div_done) begin
            c_r     <= div_q;
            state_r <= S_HSTART;
          end
        end
        S_HSTART: state_r <= S_HWAIT;
        S_HWAIT: begin
          if (sha_done) begin
            if (blk_r == 2'd1) inner_r <= sha_digest;
            if (blk_r != 2'd3) begin
              blk_r   <= blk_r + 2'd1;
              state_r <= S_HSTART;
            end else if (derive_r) begin
              key_r    <= sha_digest & DK_MASK;
              derive_r <= 1'b0;
              blk_r    <= '0;
              cand_r   <= c_r;
              step_r   <= '0;
              back_r   <= 1'b0;
              state_r  <= S_HSTART;
            end else begin
              state_r <= S_BCD;
            end
          end
        end
        S_BCD: begin
          if (bcd_done) begin
            blk_r <= '0;
            if (code == item_r.candidate_pin) begin
              res_r.accepted <= 1'b1;
              if (item_r.pin_kind == KIND_HOTP) begin
                res_r.counter_update <= 1'b1;
                res_r.next_counter   <= cand_r + 32'd1;
              end
              state_r <= S_OUT;
            end else if (!back_r && step_r != item_r.follow_window) begin
              step_r  <= step_r + 8'd1;
              cand_r  <= cand_r + 32'd1;
              state_r <= S_HSTART;
            end else if (!back_r && prev_eff != 8'd0) begin
              // forward window exhausted, walk back from the base counter
              back_r  <= 1'b1;
              step_r  <= 8'd1;
              cand_r  <= c_r - 32'd1;
              state_r <= S_HSTART;
            end else if (back_r && step_r != prev_eff) begin
              step_r  <= step_r + 8'd1;
              cand_r  <= cand_r - 32'd1;
              state_r <= S_HSTART;
            end else begin
              state_r <= S_OUT;
            end
          end
        end
        S_OUT: begin
          if (!out_valid_r || out_ready) begin
            out_r       <= res_r;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_ready)
    else $error("block still ready after taking a transaction");

  a_update_needs_accept: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!out_data.counter_update || out_data.accepted))
    else $error("counter update without acceptance");

  a_next_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.counter_update |-> out_data.next_counter == 32'd0)
    else $error("next counter set without counter update");

  a_sha_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
    sha_ctl.start |-> !bcd_start && state_r != S_BCD)
    else $error("hash started while converting digits");
`endif

endmodule
